/* rtl/core/bfsb_pkg.sv */
// Package for the box-feasible backtracking step block.
// Holds the fixed-point types, constants and datapath helper functions.
package bfsb_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic        [15:0] cfact_t;
  typedef logic        [16:0] factor_t;
  typedef logic        [5:0]  tries_t;

  localparam factor_t ONE_Q16       = 17'd65536;
  localparam cfact_t  CF_RESET      = 16'd32768;
  localparam tries_t  TRIES_RESET   = 6'd10;
  localparam int      CFG_DW        = 16;

  // Register indexes of the configuration port
  typedef enum logic {
    REG_CONTRACTION = 1'b0,
    REG_MAX_TRIES   = 1'b1
  } reg_idx_e;

  // Control for the shared multiplier
  typedef struct packed {
    logic en;
    logic use_cf;
  } mul_ctrl_t;

  // Evaluation result of one element
  typedef struct packed {
    logic in_box;
    q16_t dir;
    q16_t trial;
  } eval_t;

  // Saturate a 34-bit signed value to 32 bits
  function automatic q16_t sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      sat34 = 32'sh7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      sat34 = 32'sh8000_0000;
    end else begin
      sat34 = v[31:0];
    end
  endfunction

endpackage

/* rtl/core/bfsb_if.sv */
// Item channels of the box-feasible backtracking step block.
// Depends on bfsb_pkg for the field types.
interface bfsb_in_if;
  logic            valid;
  logic            ready;
  bfsb_pkg::q16_t  lower_bound;
  bfsb_pkg::q16_t  upper_bound;
  bfsb_pkg::q16_t  current_value;
  bfsb_pkg::q16_t  proposed_step;
  logic            last_element;

  modport source (output valid, lower_bound, upper_bound, current_value, proposed_step,
                  last_element, input ready);
  modport sink   (input valid, lower_bound, upper_bound, current_value, proposed_step,
                  last_element, output ready);
endinterface

interface bfsb_out_if;
  logic            valid;
  logic            ready;
  bfsb_pkg::q16_t  direction_value;
  bfsb_pkg::q16_t  trial_value;
  logic            was_clamped;
  logic            last_result;

  modport source (output valid, direction_value, trial_value, was_clamped, last_result,
                  input ready);
  modport sink   (input valid, direction_value, trial_value, was_clamped, last_result,
                  output ready);
endinterface

/* rtl/core/bfsb_store.sv */
// Element store: lower, upper, point and step packed in one memory word.
// One write port, one registered read port. Depends on bfsb_pkg.
module bfsb_store #(
  parameter int Depth = 64,
  parameter int AW    = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [127:0]        wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [127:0]        rdata_o
);
  logic [127:0] mem [Depth];
  logic [127:0] rdata_q;

  // Write on load, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/core/bfsb_unit.sv */
// Shared multiply unit and element evaluation (trial, box test, direction).
// Depends on bfsb_pkg.
module bfsb_unit (
  input  logic                 clk_i,
  input  bfsb_pkg::mul_ctrl_t  ctrl_i,
  input  bfsb_pkg::factor_t    factor_i,
  input  bfsb_pkg::cfact_t     cf_i,
  input  logic                 clamp_i,
  input  logic [127:0]         elem_i,
  output bfsb_pkg::factor_t    factor_next_o,
  output bfsb_pkg::eval_t      eval_o
);
  import bfsb_pkg::*;

  q16_t lo, hi, pt, st;
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] prod_q;
  logic signed [32:0] scaled;
  logic signed [33:0] sum;
  q16_t trial, tcl;
  logic signed [33:0] diff;

  assign {lo, hi, pt, st} = elem_i;

  // Shared multiplier: factor times step, or factor times contraction
  assign mul_a = $signed({1'b0, factor_i});
  assign mul_b = ctrl_i.use_cf ? $signed({17'd0, cf_i}) : $signed({st[31], st});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= 51'(mul_a * mul_b);
    end
  end

  assign factor_next_o = prod_q[32:16];
  assign scaled        = prod_q[48:16];

  // Trial point, box test, optional clamp to the box and direction
  always_comb begin
    sum   = 34'(pt) + 34'(scaled);
    trial = sat34(sum);
    tcl   = trial;
    if (tcl < lo) begin
      tcl = lo;
    end
    if (tcl > hi) begin
      tcl = hi;
    end
    diff = 34'(tcl) - 34'(pt);
    eval_o.in_box = (trial >= lo) && (trial <= hi);
    eval_o.trial  = clamp_i ? tcl : trial;
    eval_o.dir    = clamp_i ? sat34(diff) : scaled[31:0];
  end
endmodule

/* rtl/core/box_feasible_step_backtrack_top.sv */
// Box-feasible backtracking step. Load up to MAX_ELEMENTS items (lower, upper,
// point, step); the item marked last starts the search. Each try walks all
// stored elements through one shared multiplier (memory read, multiply,
// evaluate), stopping at the first element outside the box; a failed try then
// shrinks the factor by the contraction on the same multiplier. Up to max_tries
// tries are made; after the last failed one the results are clamped to the box.
// Results go out one per element (read, multiply, evaluate, offer), each held
// until the sink takes it. No item is taken while a vector is busy.
// Depends on bfsb_pkg, bfsb_if, bfsb_store and bfsb_unit.
module box_feasible_step_backtrack_top #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  bfsb_pkg::reg_idx_e       cfg_idx_i,
  input  logic [bfsb_pkg::CFG_DW-1:0] cfg_data_i,
  bfsb_in_if.sink                  in_i,
  bfsb_out_if.source               out_o
);
  import bfsb_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  typedef enum logic [2:0] {
    S_LOAD, S_RD, S_MUL, S_EVAL, S_FACT, S_FSET, S_SEND
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q, n_q;
  logic [AW-1:0]   idx_q;
  factor_t         factor_q;
  tries_t          tries_q, max_tries_q;
  cfact_t          cf_q;
  logic            phase_q, clamp_q;
  logic            out_valid_q, out_last_q;
  q16_t            out_dir_q, out_trial_q;

  logic            in_acc, store_we, elem_last;
  logic [127:0]    rdata;
  mul_ctrl_t       mctrl;
  factor_t         factor_next;
  eval_t           ev;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign store_we   = in_acc && (count_q < CW'(MAX_ELEMENTS));
  assign elem_last  = ({{(CW-AW){1'b0}}, idx_q} == n_q - CW'(1));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_q        <= CF_RESET;
      max_tries_q <= TRIES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CONTRACTION: cf_q        <= cfg_data_i;
        REG_MAX_TRIES:   max_tries_q <= cfg_data_i[5:0];
        default:         ;
      endcase
    end
  end

  bfsb_store #(.Depth(MAX_ELEMENTS), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({in_i.lower_bound, in_i.upper_bound, in_i.current_value, in_i.proposed_step}),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign mctrl.en     = (state_q == S_MUL) || (state_q == S_FACT);
  assign mctrl.use_cf = (state_q == S_FACT);

  bfsb_unit u_unit (
    .clk_i         (clk_i),
    .ctrl_i        (mctrl),
    .factor_i      (factor_q),
    .cf_i          (cf_q),
    .clamp_i       (clamp_q),
    .elem_i        (rdata),
    .factor_next_o (factor_next),
    .eval_o        (ev)
  );

  // Sequencer: load, search tries, then send one item per element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      factor_q    <= ONE_Q16;
      tries_q     <= 6'd1;
      phase_q     <= 1'b0;
      clamp_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (store_we) begin
              count_q <= count_q + CW'(1);
            end
            if (in_i.last_element) begin
              n_q      <= store_we ? count_q + CW'(1) : count_q;
              idx_q    <= '0;
              factor_q <= ONE_Q16;
              tries_q  <= 6'd1;
              phase_q  <= 1'b0;
              clamp_q  <= 1'b0;
              state_q  <= S_RD;
            end
          end
        end
        S_RD:  state_q <= S_MUL;
        S_MUL: state_q <= S_EVAL;
        S_EVAL: begin
          if (phase_q) begin
            out_dir_q   <= ev.dir;
            out_trial_q <= ev.trial;
            out_last_q  <= elem_last;
            out_valid_q <= 1'b1;
            state_q     <= S_SEND;
          end else if (!ev.in_box) begin
            state_q <= S_FACT;
          end else if (elem_last) begin
            phase_q <= 1'b1;
            idx_q   <= '0;
            state_q <= S_RD;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_RD;
          end
        end
        S_FACT: state_q <= S_FSET;
        S_FSET: begin
          factor_q <= factor_next;
          idx_q    <= '0;
          state_q  <= S_RD;
          if (tries_q >= max_tries_q) begin
            clamp_q <= 1'b1;
            phase_q <= 1'b1;
          end else begin
            tries_q <= tries_q + 6'd1;
          end
        end
        S_SEND: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              count_q  <= '0;
              factor_q <= ONE_Q16;
              state_q  <= S_LOAD;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.direction_value = out_dir_q;
  assign out_o.trial_value     = out_trial_q;
  assign out_o.was_clamped     = clamp_q;
  assign out_o.last_result     = out_last_q;
endmodule

/* rtl/core/bfsb_checker.sv */
// Port checker for the box-feasible backtracking step block, bound to the top.
// Depends only on the top level's ports.
module bfsb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_clamped
);
  // Never take an item while a result is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("input ready while result pending");

  // A last item starts work: input closes
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && in_last) |=> !in_ready) else $error("input open after last item");

  // Final result reopens the input
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && out_last) |=> in_ready) else $error("input not reopened");

  // Clamp flag holds across a vector
  a_clamp_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !out_last) |=> $stable(out_clamped))
    else $error("clamp flag changed inside a vector");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped while stalled");
endmodule

bind box_feasible_step_backtrack_top bfsb_checker u_bfsb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .in_last     (in_i.last_element),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_last    (out_o.last_result),
  .out_clamped (out_o.was_clamped)
);
